// ===== design/efas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efas_pkg
// Types and constants shared by the extended float add/sub pipeline.
// ----------------------------------------------------------------------------
package efas_pkg;

  localparam int EXP_W = 32;
  localparam int WORD_W = 64;
  localparam int SIG_W = 2 * WORD_W + 1;
  localparam int LZC_W = 8;
  localparam logic [EXP_W-1:0] SPECIAL_EXP = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_t;

  // significand: {high word, extension word, sticky}
  typedef struct packed {
    logic             sign;
    logic [EXP_W-1:0] exp;
    logic [SIG_W-1:0] sig;
  } xnum_t;

  typedef struct packed {
    logic  special;
    logic  bypass;
    xnum_t byp;
  } side_t;

endpackage

// ===== design/efas_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efas_in_if
// Operand request channel: valid/ready plus the two operands and command.
// ----------------------------------------------------------------------------
interface efas_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        a_sign;
  logic [31:0] a_exp;
  logic [63:0] a_mant;
  logic [63:0] a_ext;
  logic        a_sticky;
  logic        b_sign;
  logic [31:0] b_exp;
  logic [63:0] b_mant;
  logic [63:0] b_ext;
  logic        b_sticky;

  modport source (
    output valid, cmd, a_sign, a_exp, a_mant, a_ext, a_sticky,
           b_sign, b_exp, b_mant, b_ext, b_sticky,
    input  ready
  );
  modport sink (
    input  valid, cmd, a_sign, a_exp, a_mant, a_ext, a_sticky,
           b_sign, b_exp, b_mant, b_ext, b_sticky,
    output ready
  );
endinterface

// ===== design/efas_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efas_out_if
// Result request channel: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface efas_out_if;
  logic        valid;
  logic        ready;
  logic        res_sign;
  logic [31:0] res_exp;
  logic [63:0] res_mant;
  logic [63:0] res_ext;
  logic        res_sticky;
  logic        special_in;

  modport source (
    output valid, res_sign, res_exp, res_mant, res_ext, res_sticky, special_in,
    input  ready
  );
  modport sink (
    input  valid, res_sign, res_exp, res_mant, res_ext, res_sticky, special_in,
    output ready
  );
endinterface

// ===== design/efas_lzc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efas_lzc
// Leading zero count of a 129-bit significand (all zero gives SIG_W).
// ----------------------------------------------------------------------------
module efas_lzc (
  input  logic [efas_pkg::SIG_W-1:0] value,
  output logic [efas_pkg::LZC_W-1:0] count
);
  import efas_pkg::*;

  always_comb begin
    count = LZC_W'(SIG_W);
    for (int i = 0; i < SIG_W; i++) begin
      if (value[i]) begin
        count = LZC_W'(SIG_W - 1 - i);
      end
    end
  end

endmodule

// ===== design/extended_float_add_sub_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_float_add_sub_top
// Unrounded add/subtract of extended floats, seven-stage pipeline.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake    | payload
//  operands   | in  | valid/ready  | cmd, a_*, b_* (sign, exp, mant, ext, sticky)
//  result     | out | valid/ready  | res_*, special_in
//
//  One request per cycle while no result is held; the result becomes valid
//  in the output register once its request has passed every stage.
//  Stages: detect+lzc, normalize, exponent compare, align, add/sub,
//  result lzc, renormalize into the output register.
//  rst clears all stage valid bits. A held result freezes the whole pipe;
//  operands.ready is low only while result is valid and not taken.
// ----------------------------------------------------------------------------
module extended_float_add_sub_top (
  input logic clk,
  input logic rst,
  efas_in_if.sink    operands,
  efas_out_if.source result
);
  import efas_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld;
  logic            en;

  assign en = !vld[NSTG-1] || result.ready;
  assign operands.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], operands.valid};
    end
  end

  // stage 1 inputs
  xnum_t           a_in, b_in;
  side_t           side_in;
  logic [LZC_W-1:0] la_in, lb_in;
  logic            za, zb;

  always_comb begin
    a_in.sign = operands.a_sign;
    a_in.exp  = operands.a_exp;
    a_in.sig  = {operands.a_mant, operands.a_ext, operands.a_sticky};
    b_in.sign = operands.b_sign ^ (operands.cmd == CMD_SUB);
    b_in.exp  = operands.b_exp;
    b_in.sig  = {operands.b_mant, operands.b_ext, operands.b_sticky};
    za = (a_in.sig == '0);
    zb = (b_in.sig == '0);
    side_in.special = (a_in.exp == SPECIAL_EXP) || (b_in.exp == SPECIAL_EXP);
    side_in.bypass  = za || zb;
    side_in.byp     = (za && !zb) ? b_in : a_in;
  end

  efas_lzc u_lzc_a (.value(a_in.sig), .count(la_in));
  efas_lzc u_lzc_b (.value(b_in.sig), .count(lb_in));

  xnum_t            a1, b1;
  side_t            c1;
  logic [LZC_W-1:0] la1, lb1;

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= a_in;
      b1  <= b_in;
      c1  <= side_in;
      la1 <= la_in;
      lb1 <= lb_in;
    end
  end

  // stage 2: normalize
  xnum_t a2, b2;
  side_t c2;

  always_ff @(posedge clk) begin
    if (en) begin
      a2.sign <= a1.sign;
      a2.exp  <= a1.exp - EXP_W'(la1);
      a2.sig  <= a1.sig << la1;
      b2.sign <= b1.sign;
      b2.exp  <= b1.exp - EXP_W'(lb1);
      b2.sig  <= b1.sig << lb1;
      c2      <= c1;
    end
  end

  // stage 3: exponent compare and swap
  logic             b_big;
  logic [EXP_W-1:0] ediff;
  logic [LZC_W-1:0] dsat;

  always_comb begin
    b_big = $signed(b2.exp) > $signed(a2.exp);
    ediff = b_big ? (b2.exp - a2.exp) : (a2.exp - b2.exp);
    dsat  = (ediff >= EXP_W'(SIG_W - 1)) ? LZC_W'(SIG_W - 1) : ediff[LZC_W-1:0];
  end

  xnum_t            x3, y3;
  side_t            c3;
  logic [LZC_W-1:0] d3;
  logic             asg3;

  always_ff @(posedge clk) begin
    if (en) begin
      x3   <= b_big ? b2 : a2;
      y3   <= b_big ? a2 : b2;
      d3   <= dsat;
      asg3 <= a2.sign;
      c3   <= c2;
    end
  end

  // stage 4: align smaller operand
  logic [SIG_W-2:0] ymask;
  xnum_t            y_al;

  always_comb begin
    ymask     = ~({(SIG_W-1){1'b1}} << d3);
    y_al.sign = y3.sign;
    y_al.exp  = x3.exp;
    y_al.sig  = {y3.sig[SIG_W-1:1] >> d3,
                 y3.sig[0] | (|(y3.sig[SIG_W-1:1] & ymask))};
  end

  xnum_t x4, y4;
  side_t c4;
  logic  asg4;

  always_ff @(posedge clk) begin
    if (en) begin
      x4   <= x3;
      y4   <= y_al;
      asg4 <= asg3;
      c4   <= c3;
    end
  end

  // stage 5: add or subtract magnitudes
  logic [SIG_W:0] sum, dxy, dyx;
  xnum_t          m_nx;
  logic           z_nx;

  always_comb begin
    sum  = {1'b0, x4.sig} + {1'b0, y4.sig};
    dxy  = {1'b0, x4.sig} - {1'b0, y4.sig};
    dyx  = {1'b0, y4.sig} - {1'b0, x4.sig};
    m_nx = x4;
    z_nx = 1'b0;
    if (x4.sign == y4.sign) begin
      if (sum[SIG_W]) begin
        m_nx.sig = {1'b1, sum[SIG_W-1:2], sum[1] | sum[0]};
        m_nx.exp = x4.exp + 32'd1;
      end else begin
        m_nx.sig = sum[SIG_W-1:0];
      end
    end else if (dxy == '0) begin
      z_nx = 1'b1;
    end else if (dxy[SIG_W]) begin
      m_nx.sig  = dyx[SIG_W-1:0];
      m_nx.sign = y4.sign;
    end else begin
      m_nx.sig = dxy[SIG_W-1:0];
    end
  end

  xnum_t m5;
  logic  z5, asg5;
  side_t c5;

  always_ff @(posedge clk) begin
    if (en) begin
      m5   <= m_nx;
      z5   <= z_nx;
      asg5 <= asg4;
      c5   <= c4;
    end
  end

  // stage 6: result leading zeros
  logic [LZC_W-1:0] lm_nx;

  efas_lzc u_lzc_r (.value(m5.sig), .count(lm_nx));

  xnum_t            m6;
  logic             z6, asg6;
  side_t            c6;
  logic [LZC_W-1:0] lm6;

  always_ff @(posedge clk) begin
    if (en) begin
      m6   <= m5;
      z6   <= z5;
      asg6 <= asg5;
      c6   <= c5;
      lm6  <= lm_nx;
    end
  end

  // stage 7: renormalize and select
  xnum_t r_nx;

  always_comb begin
    if (c6.special) begin
      r_nx = '0;
    end else if (c6.bypass) begin
      r_nx = c6.byp;
    end else if (z6) begin
      r_nx      = '0;
      r_nx.sign = asg6;
    end else begin
      r_nx.sign = m6.sign;
      r_nx.exp  = m6.exp - EXP_W'(lm6);
      r_nx.sig  = m6.sig << lm6;
    end
  end

  xnum_t r7;
  logic  sp7;

  always_ff @(posedge clk) begin
    if (en) begin
      r7  <= r_nx;
      sp7 <= c6.special;
    end
  end

  assign result.valid      = vld[NSTG-1];
  assign result.res_sign   = r7.sign;
  assign result.res_exp    = r7.exp;
  assign result.res_mant   = r7.sig[SIG_W-1 -: WORD_W] & ALL_ONES;
  assign result.res_ext    = r7.sig[WORD_W:1];
  assign result.res_sticky = r7.sig[0];
  assign result.special_in = sp7;

endmodule

// ===== design/efas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efas_checker
// Port-level checks for the add/sub pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module efas_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        res_sign,
  input logic [31:0] res_exp,
  input logic [63:0] res_mant,
  input logic [63:0] res_ext,
  input logic        res_sticky,
  input logic        special_in
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && special_in |->
      !res_sign && res_exp == '0 && res_mant == '0 && res_ext == '0 && !res_sticky)
    else $error("special result not zero");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipe stalled with no result held");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while result held");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_exp) && $stable(res_mant))
    else $error("held result changed");

endmodule

bind extended_float_add_sub_top efas_checker u_efas_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (operands.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .res_sign   (result.res_sign),
  .res_exp    (result.res_exp),
  .res_mant   (result.res_mant),
  .res_ext    (result.res_ext),
  .res_sticky (result.res_sticky),
  .special_in (result.special_in)
);

// ===== tb/extended_float_add_sub_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_float_add_sub_top_tb
// Drives operand requests into the extended float adder with random idling
// and back-pressure, predicts each sum or difference bit-exactly and
// checks every result request in order.
// ----------------------------------------------------------------------------
module extended_float_add_sub_top_tb;
  import efas_pkg::*;

  typedef struct {
    logic        sign;
    logic [31:0] exp;
    logic [63:0] mant;
    logic [63:0] ext;
    logic        sticky;
    logic        special;
  } sum_t;

  typedef struct {
    cmd_t        cmd;
    logic        a_sign;
    logic [31:0] a_exp;
    logic [63:0] a_mant;
    logic [63:0] a_ext;
    logic        a_sticky;
    logic        b_sign;
    logic [31:0] b_exp;
    logic [63:0] b_mant;
    logic [63:0] b_ext;
    logic        b_sticky;
  } opnd_t;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   errors = 0;
  bit   idle_off = 0;
  bit   hold_rx = 0;
  int   hold_left = 0;
  sum_t expected_sums[$];

  efas_in_if  operands();
  efas_out_if result();

  extended_float_add_sub_top dut (
    .clk(clk), .rst(rst), .operands(operands), .result(result)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("extended_float_add_sub_top_tb NOT OK");
      $finish;
    end
  end

  // -------------------- predictor --------------------
  function automatic logic [31:0] okey(logic [31:0] e);
    return e ^ 32'h8000_0000;
  endfunction

  function automatic void norm_sig(ref logic [128:0] s, ref logic [31:0] e);
    if (s == '0) return;
    while (!s[128]) begin
      s = s << 1;
      e = e - 1;
    end
  endfunction

  function automatic logic [128:0] shr_sticky(logic [128:0] s, logic [31:0] d);
    logic lost;
    if (d >= 128) return {128'b0, |s};
    lost = 0;
    for (int i = 0; i < d; i++) begin
      lost |= s[1];
      s = {1'b0, s[128:2], s[0]};
    end
    s[0] = s[0] | lost;
    return s;
  endfunction

  function automatic sum_t predict_sum(opnd_t op);
    sum_t r;
    logic [128:0] x, y, z;
    logic [31:0] xe, ye;
    logic xs, ys;
    logic [129:0] wide;
    r = '{default: '0};
    if (op.a_exp == SPECIAL_EXP || op.b_exp == SPECIAL_EXP) begin
      r.special = 1;
      return r;
    end
    x = {op.a_mant, op.a_ext, op.a_sticky};
    y = {op.b_mant, op.b_ext, op.b_sticky};
    xs = op.a_sign;
    ys = op.b_sign ^ (op.cmd == CMD_SUB);
    xe = op.a_exp;
    ye = op.b_exp;
    if (x == '0 && y != '0) begin
      {r.mant, r.ext, r.sticky} = y;
      r.sign = ys;
      r.exp = ye;
      return r;
    end
    if (x == '0 || y == '0) begin
      {r.mant, r.ext, r.sticky} = x;
      r.sign = xs;
      r.exp = xe;
      return r;
    end
    norm_sig(x, xe);
    norm_sig(y, ye);
    if (okey(xe) > okey(ye)) begin
      y = shr_sticky(y, okey(xe) - okey(ye));
      ye = xe;
    end else if (okey(ye) > okey(xe)) begin
      x = shr_sticky(x, okey(ye) - okey(xe));
      xe = ye;
    end
    r.exp = xe;
    if (xs == ys) begin
      r.sign = xs;
      wide = {1'b0, x[128:1], 1'b0} + {1'b0, y[128:1], 1'b0}
             + {128'b0, x[0] & y[0], 1'b0};
      z = {wide[128:1], x[0] ^ y[0]};
      if (wide[129]) begin
        z = shr_sticky(z, 1);
        z[128] = 1;
        r.exp = r.exp + 1;
      end
    end else begin
      if (x == y) begin
        r.sign = op.a_sign;
        r.exp = 0;
        return r;
      end
      if (x > y) begin
        z = x - y;
        r.sign = xs;
      end else begin
        z = y - x;
        r.sign = ys;
      end
    end
    norm_sig(z, r.exp);
    {r.mant, r.ext, r.sticky} = z;
    return r;
  endfunction

  // -------------------- result checker --------------------
  always @(posedge clk) begin
    sum_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result request");
        errors++;
      end else begin
        e = expected_sums.pop_front();
        if (result.res_sign !== e.sign) begin
          $error("res_sign exp %0h got %0h", e.sign, result.res_sign); errors++;
        end
        if (result.res_exp !== e.exp) begin
          $error("res_exp exp %0h got %0h", e.exp, result.res_exp); errors++;
        end
        if (result.res_mant !== e.mant) begin
          $error("res_mant exp %0h got %0h", e.mant, result.res_mant); errors++;
        end
        if (result.res_ext !== e.ext) begin
          $error("res_ext exp %0h got %0h", e.ext, result.res_ext); errors++;
        end
        if (result.res_sticky !== e.sticky) begin
          $error("res_sticky exp %0h got %0h", e.sticky, result.res_sticky); errors++;
        end
        if (result.special_in !== e.special) begin
          $error("special_in exp %0h got %0h", e.special, result.special_in); errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result.ready <= 0;
    end else if (hold_rx) begin
      hold_left <= 60;
      result.ready <= 0;
    end else begin
      result.ready <= idle_off || ($urandom_range(99) >= 12);
    end
  end

  // -------------------- stimulus --------------------
  task automatic send_request(opnd_t op);
    while (!idle_off && $urandom_range(99) < 12) begin
      operands.valid <= 0;
      @(negedge clk);
    end
    operands.valid <= 1;
    operands.cmd <= op.cmd;
    operands.a_sign <= op.a_sign;
    operands.a_exp <= op.a_exp;
    operands.a_mant <= op.a_mant;
    operands.a_ext <= op.a_ext;
    operands.a_sticky <= op.a_sticky;
    operands.b_sign <= op.b_sign;
    operands.b_exp <= op.b_exp;
    operands.b_mant <= op.b_mant;
    operands.b_ext <= op.b_ext;
    operands.b_sticky <= op.b_sticky;
    do @(posedge clk); while (!operands.ready);
    expected_sums.push_back(predict_sum(op));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    operands.valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic opnd_t rand_opnd();
    opnd_t op;
    op.cmd = cmd_t'($urandom_range(1));
    op.a_sign = 1'($urandom_range(1));
    op.b_sign = 1'($urandom_range(1));
    op.a_sticky = 1'($urandom_range(1));
    op.b_sticky = 1'($urandom_range(1));
    op.a_mant = rand64();
    op.a_ext = rand64();
    op.b_mant = rand64();
    op.b_ext = rand64();
    case ($urandom_range(9))
      0: op.a_mant = op.a_mant >> $urandom_range(63);
      1: op.b_mant = 0;
      2: begin op.a_mant = 0; op.a_ext = op.a_ext >> $urandom_range(63); end
      3: begin op.b_mant = op.a_mant; op.b_ext = op.a_ext ^ 64'($urandom_range(3)); end
      default: ;
    endcase
    op.a_exp = $urandom();
    case ($urandom_range(7))
      0: op.b_exp = $urandom();
      1: op.b_exp = op.a_exp + $urandom_range(300) - 150;
      2: op.b_exp = SPECIAL_EXP;
      default: op.b_exp = op.a_exp + $urandom_range(8) - 4;
    endcase
    if ($urandom_range(99) < 2) op.a_exp = SPECIAL_EXP;
    return op;
  endfunction

  task automatic wait_drained();
    while (expected_sums.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    opnd_t op;
    logic [31:0] exps[5] = '{32'h8000_0000, 32'h7FFF_FFFE, 0, SPECIAL_EXP, 32'hFFFF_FFFF};
    for (int i = 0; i < 20; i++) begin
      op = rand_opnd();
      op.cmd = cmd_t'(i % 2);
      op.a_exp = exps[i % 5];
      op.b_exp = exps[(i / 2) % 5];
      case (i % 4)
        0: begin op.a_mant = ALL_ONES; op.a_ext = ALL_ONES; op.a_sticky = 1;
                 op.b_mant = ALL_ONES; op.b_ext = ALL_ONES; op.b_sticky = 1;
                 op.b_sign = op.a_sign ^ op.cmd; end
        1: begin op.a_mant = 0; op.a_ext = 0; op.a_sticky = 0; end
        2: begin op.b_mant = 0; op.b_ext = 0; op.b_sticky = i[3]; end
        3: begin op.b_mant = op.a_mant; op.b_ext = op.a_ext;
                 op.b_sticky = op.a_sticky; op.b_exp = op.a_exp;
                 op.b_sign = op.a_sign ^ ~op.cmd; end
        default: ;
      endcase
      send_request(op);
    end
    op = rand_opnd(); op.a_mant = 0; op.a_ext = 0; op.a_sticky = 0;
    op.b_mant = 0; op.b_ext = 0; op.b_sticky = 0; op.a_exp = 5; op.b_exp = 9;
    send_request(op);
    stop_sending();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_request(rand_opnd());
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_rx = 1;
    wait (hold_left > 0);
    hold_rx = 0;
    test_random(30);
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_off = 1;
    test_random(200);
    idle_off = 0;
  endtask

  initial begin
    operands.valid = 0;
    operands.cmd = CMD_ADD;
    operands.a_sign = 0; operands.a_exp = 0; operands.a_mant = 0;
    operands.a_ext = 0; operands.a_sticky = 0;
    operands.b_sign = 0; operands.b_exp = 0; operands.b_mant = 0;
    operands.b_ext = 0; operands.b_sticky = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random(500);
    test_backpressure();
    test_no_idle();
    test_random(500);
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("extended_float_add_sub_top_tb OK");
    end else begin
      $display("extended_float_add_sub_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/efas_pkg.sv
design/efas_in_if.sv
design/efas_out_if.sv
design/efas_lzc.sv
design/extended_float_add_sub_top.sv
design/efas_checker.sv
tb/extended_float_add_sub_top_tb.sv
